// ===== hw/rtl/stack_allocator_with_length_check_defines.svh =====
// Assertion macros for the stack allocator RTL.
`ifndef STACK_ALLOCATOR_WITH_LENGTH_CHECK_DEFINES_SVH
`define STACK_ALLOCATOR_WITH_LENGTH_CHECK_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on clk, disabled while rst_n is low.
`define SA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on clk at every edge, reset included.
`define SA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SA_ASSERT(lbl, prop, msg)
`define SA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== hw/rtl/sa_pkg.sv =====
// Shared types and constants of the stack allocator.
package sa_pkg;

    localparam int unsigned LEN_W  = 16;
    localparam int unsigned USED_W = 17;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_POP   = 2'd2,
        OP_TOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_OOM     = 3'd1,
        ST_CORRUPT = 3'd2,
        ST_REFUSED = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

    typedef logic [LEN_W-1:0] len_t;

endpackage

// ===== hw/rtl/sa_len_ram.sv =====
// Block length memory: one write port, one read port, registered read data.
module sa_len_ram
    import sa_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  len_t          wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output len_t          rdata
);

    len_t mem [DEPTH];
    len_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/stack_allocator_with_length_check.sv =====
// LIFO arena allocator: an APB-programmed pool size, a stream of requests, one result per request.
// Each request is accepted in S_IDLE, then executed against the allocator state in S_EXEC. A free
// or pop that leaves blocks on the stack also passes through S_FILL, where the cached top length
// is refilled from the length memory through its single registered read port. A result waits in the output
// register; the next request is accepted meanwhile, and only an execute that finds the output
// register still full holds until it is taken. The length memory needs no clearing after reset
// or after a pool_size write, since only entries below the block count are ever read.
module stack_allocator_with_length_check
    import sa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS   = 64,
    parameter int unsigned HEADER_BYTES = 8,
    parameter int unsigned POOL_BYTES   = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // block_bytes[15:0], block_offset[31:16]
    input  logic [1:0]  s_axis_tuser,   // op[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // ok[0], offset[16:1], length[32:17], used[49:33],
                                        // status[52:50], oom_flag[53], corrupt_flag[54], zero[55]
);

    localparam int unsigned AW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [USED_W-1:0] POOL_RST =
        (POOL_BYTES < 65536) ? USED_W'(POOL_BYTES) : USED_W'(65536);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FILL
    } state_t;

    state_t              state_reg, state_next;
    logic [USED_W-1:0]   pool_reg, pool_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    len_t                top_len_reg, top_len_next;
    logic                oom_reg, oom_next;
    logic                corrupt_reg, corrupt_next;
    op_t                 op_reg;
    len_t                bytes_reg;
    len_t                offs_reg;
    logic                m_valid_reg, m_valid_next;
    logic [55:0]         m_data_reg, m_data_next;

    logic                cfg_wr;
    logic [USED_W-1:0]   cfg_pool;
    logic                out_free;
    logic [USED_W-1:0]   top_off;
    logic [USED_W:0]     fit_sum;
    logic                stack_empty;
    logic                stack_full;
    status_t             status;
    len_t                r_off;
    len_t                r_len;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    len_t                mem_rdata;
    logic [CNT_W-1:0]    cnt_m2;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign cfg_pool = (32'(pwdata[USED_W-1:0]) > POOL_BYTES) ? USED_W'(POOL_BYTES)
                                                            : pwdata[USED_W-1:0];
    assign prdata = (paddr[2] == 1'b0) ? 32'(pool_reg) : 32'd0;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign stack_empty = (cnt_reg == '0);
    assign stack_full  = (cnt_reg == CNT_W'(MAX_BLOCKS));
    assign top_off     = used_reg - USED_W'(top_len_reg) - USED_W'(HEADER_BYTES);
    assign fit_sum     = {1'b0, used_reg} + (USED_W+1)'(bytes_reg)
                         + (USED_W+1)'(HEADER_BYTES);
    assign cnt_m2      = cnt_reg - CNT_W'(2);

    sa_len_ram #(
        .DEPTH (MAX_BLOCKS),
        .AW    (AW)
    ) u_len_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (bytes_reg),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        pool_next    = pool_reg;
        used_next    = used_reg;
        cnt_next     = cnt_reg;
        top_len_next = top_len_reg;
        oom_next     = oom_reg;
        corrupt_next = corrupt_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        status       = ST_OK;
        r_off        = '0;
        r_len        = '0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = cnt_m2[AW-1:0];

        // the held request acts on the allocator only in the execute cycle
        if (state_reg == S_EXEC)
        begin
            case (op_reg)
                OP_ALLOC:
                begin
                    if (bytes_reg == '0)
                    begin
                        status = ST_EMPTY;
                    end
                    else if (oom_reg || corrupt_reg)
                    begin
                        status = ST_REFUSED;
                    end
                    else if (stack_full || (fit_sum > {1'b0, pool_reg}))
                    begin
                        status   = ST_OOM;
                        oom_next = 1'b1;
                    end
                    else
                    begin
                        r_off        = used_reg[LEN_W-1:0];
                        r_len        = bytes_reg;
                        used_next    = fit_sum[USED_W-1:0];
                        cnt_next     = cnt_reg + CNT_W'(1);
                        top_len_next = bytes_reg;
                        mem_we       = 1'b1;
                    end
                end
                OP_FREE, OP_POP:
                begin
                    if (op_reg == OP_POP && stack_empty)
                    begin
                        status = ST_EMPTY;
                    end
                    else if (corrupt_reg)
                    begin
                        status = ST_REFUSED;
                    end
                    else if (stack_empty)
                    begin
                        status       = ST_CORRUPT;
                        corrupt_next = 1'b1;
                    end
                    else if (op_reg == OP_FREE &&
                             (top_len_reg != bytes_reg || top_off[LEN_W-1:0] != offs_reg))
                    begin
                        status       = ST_CORRUPT;
                        corrupt_next = 1'b1;
                    end
                    else
                    begin
                        r_off     = top_off[LEN_W-1:0];
                        r_len     = top_len_reg;
                        used_next = top_off;
                        cnt_next  = cnt_reg - CNT_W'(1);
                        mem_re    = (cnt_reg != CNT_W'(1));
                    end
                end
                OP_TOP:
                begin
                    if (stack_empty)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        r_off = top_off[LEN_W-1:0];
                        r_len = top_len_reg;
                    end
                end
                default:
                begin
                    status = ST_EMPTY;
                end
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, corrupt_next, oom_next, status, used_next,
                                    r_len, r_off, (status == ST_OK)};
                    state_next   = mem_re ? S_FILL : S_IDLE;
                end
                else
                begin
                    // hold all state until the output register frees up
                    used_next    = used_reg;
                    cnt_next     = cnt_reg;
                    top_len_next = top_len_reg;
                    oom_next     = oom_reg;
                    corrupt_next = corrupt_reg;
                    mem_we       = 1'b0;
                    mem_re       = 1'b0;
                end
            end
            S_FILL:
            begin
                top_len_next = mem_rdata;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            pool_next    = cfg_pool;
            used_next    = '0;
            cnt_next     = '0;
            oom_next     = 1'b0;
            corrupt_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pool_reg    <= POOL_RST;
            used_reg    <= '0;
            cnt_reg     <= '0;
            oom_reg     <= 1'b0;
            corrupt_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pool_reg    <= pool_next;
            used_reg    <= used_next;
            cnt_reg     <= cnt_next;
            oom_reg     <= oom_next;
            corrupt_reg <= corrupt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        top_len_reg <= top_len_next;
        m_data_reg  <= m_data_next;
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg    <= op_t'(s_axis_tuser);
            bytes_reg <= s_axis_tdata[15:0];
            offs_reg  <= s_axis_tdata[31:16];
        end
    end

`include "stack_allocator_with_length_check_defines.svh"

    `SA_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(MAX_BLOCKS), "block count above limit")
    `SA_ASSERT_ALWAYS(a_used_bound, used_reg <= pool_reg, "used bytes exceed pool size")
    `SA_ASSERT_ALWAYS(a_empty_used, (cnt_reg != '0) || (used_reg == '0),
                      "empty stack with bytes in use")
    `SA_ASSERT(a_result_src, $rose(m_axis_tvalid) |-> $past(state_reg) == S_EXEC,
               "result raised outside execute")

endmodule
